// ----- hdl/rct_pkg.sv -----
// Shared types and codes for the reference count table.
`timescale 1ns / 1ps

package rct_pkg;

    // Table sizing defaults
    localparam int ENTRIES_DEFAULT      = 16;
    localparam int ADDRESS_BITS_DEFAULT = 48;

    // Fixed field widths
    localparam int ADDR_W  = 48;
    localparam int COUNT_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Action codes (code 3 behaves as a query)
    localparam logic [1:0] ACT_ADD     = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_QUERY   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Request token that walks the cell chain
    typedef struct packed {
        logic               valid;
        logic [1:0]         action;
        logic               done;    // request already resolved
        logic               alloc;   // a free cell took the key
        logic [COUNT_W-1:0] count;
        logic [1:0]         status;
    } token_t;

endpackage

// ----- hdl/rct_cell.sv -----
// One table entry: holds a key and its count, serves the passing request token.
`timescale 1ns / 1ps

module rct_cell #(
    parameter int INDEX   = 0,
    parameter int KEY_W   = 48,
    parameter int USED_W  = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [USED_W-1:0]   used,
    input  rct_pkg::token_t     tok_in,
    input  logic [KEY_W-1:0]    key_in,
    output rct_pkg::token_t     tok_out,
    output logic [KEY_W-1:0]    key_out
);

    localparam logic [USED_W-1:0] MY_INDEX = USED_W'(INDEX);

    logic [KEY_W-1:0]            addr_reg;
    logic [rct_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        write_addr;
    logic                        write_count;
    rct_pkg::token_t             tok_reg, tok_next;
    logic [KEY_W-1:0]            key_reg;
    logic                        in_use;
    logic                        hit;

    assign in_use = (MY_INDEX < used);
    assign hit    = in_use && (addr_reg == key_in);

    // Match, update or allocate for the token in front of this cell
    always_comb
    begin
        tok_next    = tok_in;
        count_next  = count_reg;
        write_addr  = 1'b0;
        write_count = 1'b0;
        if (tok_in.valid && !tok_in.done)
        begin
            if (hit)
            begin
                case (tok_in.action)
                    rct_pkg::ACT_ADD:
                    begin
                        if (count_reg != rct_pkg::COUNT_MAX)
                            count_next = count_reg + 1'b1;
                        write_count = 1'b1;
                    end
                    rct_pkg::ACT_RELEASE:
                    begin
                        if (count_reg != '0)
                            count_next = count_reg - 1'b1;
                        write_count = 1'b1;
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
                tok_next.done   = 1'b1;
                tok_next.count  = count_next;
                tok_next.status = rct_pkg::ST_OK;
            end
            else if ((MY_INDEX == used) && (tok_in.action == rct_pkg::ACT_ADD))
            begin
                // first free entry: take the key
                count_next      = rct_pkg::COUNT_W'(1);
                write_addr      = 1'b1;
                write_count     = 1'b1;
                tok_next.done   = 1'b1;
                tok_next.alloc  = 1'b1;
                tok_next.count  = rct_pkg::COUNT_W'(1);
                tok_next.status = rct_pkg::ST_OK;
            end
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (write_addr)
            addr_reg <= key_in;
        if (write_count)
            count_reg <= count_next;
    end

    // Token hand-off to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_in;
    end

    assign tok_out = tok_reg;
    assign key_out = key_reg;

endmodule

// ----- hdl/reference_count_table.sv -----
// Top level of the reference count table: request entry, cell chain, result stage.
//
//   channel   signals                     direction  beat taken when
//   request   start, action, address      in         start && !busy
//   result    done, count, status         out        done (one cycle, no stall)
//
// A request walks the chain one cell per cycle; each cell compares it with its
// own entry. The result is registered after the last cell, and busy stays high
// until done, so no new request is taken while one is in the chain. Reset
// empties the table at once (the fill count goes to zero).
// The receiver cannot stall: done is high for exactly one cycle per request.
`timescale 1ns / 1ps

module reference_count_table #(
    parameter int ENTRIES      = rct_pkg::ENTRIES_DEFAULT,
    parameter int ADDRESS_BITS = rct_pkg::ADDRESS_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  action,
    input  logic [rct_pkg::ADDR_W-1:0]  address,
    output logic                        done,
    output logic [rct_pkg::COUNT_W-1:0] count,
    output logic [1:0]                  status
);

    localparam int KEY_W  = (ADDRESS_BITS < rct_pkg::ADDR_W) ? ADDRESS_BITS : rct_pkg::ADDR_W;
    localparam int USED_W = $clog2(ENTRIES + 1);
    localparam logic [USED_W-1:0] USED_MAX = USED_W'(ENTRIES);

    rct_pkg::token_t             tok   [0:ENTRIES];
    logic [KEY_W-1:0]            key   [0:ENTRIES];
    logic [USED_W-1:0]           used_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [rct_pkg::COUNT_W-1:0] count_reg;
    logic [1:0]                  status_reg;
    logic                        accept;
    rct_pkg::token_t             last;

    assign accept = start && !busy_reg;

    // Entry token built from the request beat
    always_comb
    begin
        key[0]        = address[KEY_W-1:0];
        tok[0]        = '0;
        tok[0].valid  = accept;
        tok[0].action = action;
        if (address[KEY_W-1:0] == '0)
        begin
            tok[0].done   = 1'b1;
            tok[0].status = rct_pkg::ST_NULL;
        end
        else
        begin
            tok[0].status = rct_pkg::ST_OK;
        end
    end

    // Cell chain
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        rct_cell #(
            .INDEX  (i),
            .KEY_W  (KEY_W),
            .USED_W (USED_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .used    (used_reg),
            .tok_in  (tok[i]),
            .key_in  (key[i]),
            .tok_out (tok[i+1]),
            .key_out (key[i+1])
        );
    end

    assign last = tok[ENTRIES];

    // Busy flag, fill count and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            used_reg <= '0;
        end
        else
        begin
            done_reg <= last.valid;
            if (accept)
                busy_reg <= 1'b1;
            else if (last.valid)
                busy_reg <= 1'b0;
            if (last.valid && last.alloc)
                used_reg <= used_reg + 1'b1;
        end
    end

    // Unresolved at the chain end: full on add, otherwise not found
    always_ff @(posedge clk)
    begin
        if (last.valid)
        begin
            if (last.done)
            begin
                count_reg  <= last.count;
                status_reg <= last.status;
            end
            else
            begin
                count_reg  <= '0;
                status_reg <= (last.action == rct_pkg::ACT_ADD) ? rct_pkg::ST_FULL
                                                                 : rct_pkg::ST_NOT_FOUND;
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign count  = count_reg;
    assign status = status_reg;

`ifndef SYNTHESIS
    // A result only shows once the request has left the chain
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result while still busy");

    // Fill count never passes the table size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_MAX)
        else $error("fill count beyond table size");

    // Fill count moves only with an ok result of count one
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |->
            (done_reg && status_reg == rct_pkg::ST_OK && count_reg == rct_pkg::COUNT_W'(1)))
        else $error("fill count changed without an allocation");

    // Failed requests report a zero count
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != rct_pkg::ST_OK) |-> (count_reg == '0))
        else $error("nonzero count on failed request");

    // An accepted beat holds the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg)
        else $error("request accepted but not busy");
`endif

endmodule
